// ===== hw/rtl/spisrv_pkg.sv =====
// Package for the SPI register file / servo packet block.
// Request and reply types, byte select codes and packet constants.
// No dependencies.
package spisrv_pkg;

	localparam int unsigned REG_COUNT = 128;
	localparam int unsigned ADDR_W    = 7;

	localparam logic       KIND_WRITE = 1'b0;
	localparam logic       KIND_READ  = 1'b1;

	localparam logic [6:0] TRIGGER_REG = 7'h7f;
	localparam logic [7:0] TRIGGER_CLR = 8'hfe;
	localparam logic [7:0] PKT_CMD     = 8'ha4;

	localparam logic [15:0] CONV_LOW  = 16'd800;
	localparam logic [15:0] CONV_HIGH = 16'd2200;
	localparam int unsigned DIFF_W    = 11;
	localparam int unsigned PROD_W    = 25;
	localparam logic [PROD_W-1:0] CONV_MUL = 25'd23967;
	localparam logic [7:0] CRC_POLY   = 8'h8c;

	localparam logic RTYPE_READ   = 1'b0;
	localparam logic RTYPE_PACKET = 1'b1;

	// byte sources for the reply register
	localparam logic [2:0] SEL_READ = 3'd0;
	localparam logic [2:0] SEL_CMD  = 3'd1;
	localparam logic [2:0] SEL_LEN  = 3'd2;
	localparam logic [2:0] SEL_ZERO = 3'd3;
	localparam logic [2:0] SEL_ID   = 3'd4;
	localparam logic [2:0] SEL_VHI  = 3'd5;
	localparam logic [2:0] SEL_VLO  = 3'd6;
	localparam logic [2:0] SEL_CRC  = 3'd7;

	typedef struct packed {
		logic       kind;
		logic [6:0] reg_index;
		logic [7:0] write_byte;
	} req_t;

	typedef struct packed {
		logic       result_type;
		logic [7:0] out_byte;
		logic       last_byte;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic       acc_rd;
		logic       acc_wr;
		logic       ch_re;
		logic       ch_hi;
		logic       cap_lo;
		logic       cap_raw;
		logic       mul_en;
		logic       out_load;
		logic [2:0] out_sel;
		logic       crc_clr;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_read;
		logic is_trig;
		logic out_free;
	} sts_t;

	// Dallas/Maxim CRC-8, reflected, one byte
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/spisrv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module spisrv_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/spisrv_dp.sv =====
// Datapath: register file, value conversion, CRC and reply register.
// Depends on spisrv_pkg and spisrv_ram.
module spisrv_dp #(
	parameter int unsigned CHANNEL_COUNT = 8,
	parameter int unsigned CH_W          = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spisrv_pkg::req_t    req,
	input  spisrv_pkg::cmd_t    cmd,
	input  logic [CH_W-1:0]     ch,
	output spisrv_pkg::sts_t    sts,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output spisrv_pkg::rsp_t    rsp
);

	localparam logic [7:0] LEN_BYTE = 8'(2 + 4 * CHANNEL_COUNT);

	logic [spisrv_pkg::REG_COUNT-1:0] vld_q;
	logic                             rvld_q;
	logic [7:0]                       ram_q;
	logic [7:0]                       rd_byte;
	logic [7:0]                       lo_q;
	logic [15:0]                      raw;
	logic                             we;
	logic [7:0]                       wdata;
	logic                             re;
	logic [spisrv_pkg::ADDR_W-1:0]    raddr;
	logic [spisrv_pkg::DIFF_W-1:0]    diff_s1;
	logic                             clamp_lo_s1;
	logic                             clamp_hi_s1;
	logic [spisrv_pkg::PROD_W-1:0]    prod_s2;
	logic                             clamp_lo_s2;
	logic                             clamp_hi_s2;
	logic [15:0]                      value;
	logic [7:0]                       crc_q;
	logic [7:0]                       sel_byte;
	logic                             out_valid_q;
	spisrv_pkg::rsp_t                 out_q;
	spisrv_pkg::rsp_t                 out_d;

	assign sts.is_read  = (req.kind == spisrv_pkg::KIND_READ);
	assign sts.is_trig  = (req.reg_index == spisrv_pkg::TRIGGER_REG) && req.write_byte[0];
	assign sts.out_free = !out_valid_q || !rsp_stall;

	// register file port control
	assign we    = cmd.acc_wr;
	assign wdata = sts.is_trig ? (req.write_byte & spisrv_pkg::TRIGGER_CLR) : req.write_byte;
	assign re    = cmd.acc_rd || cmd.ch_re;
	assign raddr = cmd.acc_rd ? req.reg_index : spisrv_pkg::ADDR_W'({ch, cmd.ch_hi});

	spisrv_ram #(
		.WIDTH(8),
		.DEPTH(spisrv_pkg::REG_COUNT)
	) u_regs (
		.clk  (clk),
		.we   (we),
		.waddr(req.reg_index),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(ram_q)
	);

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[req.reg_index] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rd_byte = rvld_q ? ram_q : 8'h00;
	assign raw     = {rd_byte, lo_q};

	always_ff @(posedge clk) begin
		if (cmd.cap_lo) begin
			lo_q <= rd_byte;
		end
		if (cmd.cap_raw) begin
			diff_s1     <= spisrv_pkg::DIFF_W'(raw - spisrv_pkg::CONV_LOW);
			clamp_lo_s1 <= (raw <= spisrv_pkg::CONV_LOW);
			clamp_hi_s1 <= (raw >= spisrv_pkg::CONV_HIGH);
		end
		if (cmd.mul_en) begin
			prod_s2     <= spisrv_pkg::PROD_W'(diff_s1) * spisrv_pkg::CONV_MUL;
			clamp_lo_s2 <= clamp_lo_s1;
			clamp_hi_s2 <= clamp_hi_s1;
		end
	end

	always_comb begin
		if (clamp_hi_s2) begin
			value = 16'hffff;
		end else if (clamp_lo_s2) begin
			value = 16'h0000;
		end else begin
			value = prod_s2[24:9];
		end
	end

	always_comb begin
		unique case (cmd.out_sel)
			spisrv_pkg::SEL_READ: sel_byte = rd_byte;
			spisrv_pkg::SEL_CMD:  sel_byte = spisrv_pkg::PKT_CMD;
			spisrv_pkg::SEL_LEN:  sel_byte = LEN_BYTE;
			spisrv_pkg::SEL_ZERO: sel_byte = 8'h00;
			spisrv_pkg::SEL_ID:   sel_byte = 8'(ch) + 8'd1;
			spisrv_pkg::SEL_VHI:  sel_byte = value[15:8];
			spisrv_pkg::SEL_VLO:  sel_byte = value[7:0];
			spisrv_pkg::SEL_CRC:  sel_byte = crc_q;
			default:              sel_byte = 8'h00;
		endcase
	end

	assign out_d.result_type = (cmd.out_sel == spisrv_pkg::SEL_READ) ?
		spisrv_pkg::RTYPE_READ : spisrv_pkg::RTYPE_PACKET;
	assign out_d.out_byte    = sel_byte;
	assign out_d.last_byte   = (cmd.out_sel == spisrv_pkg::SEL_READ) ||
		(cmd.out_sel == spisrv_pkg::SEL_CRC);

	// running CRC over every packet byte but the CRC itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 8'h00;
		end else if (cmd.crc_clr) begin
			crc_q <= 8'h00;
		end else if (cmd.out_load && (cmd.out_sel != spisrv_pkg::SEL_READ) &&
			(cmd.out_sel != spisrv_pkg::SEL_CRC)) begin
			crc_q <= spisrv_pkg::crc8_step(crc_q, sel_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ===== hw/rtl/spisrv_ctrl.sv =====
// Controller state machine: request acceptance and packet sequencing.
// Depends on spisrv_pkg.
module spisrv_ctrl #(
	parameter int unsigned CHANNEL_COUNT = 8,
	parameter int unsigned CH_W          = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  spisrv_pkg::sts_t sts,
	output spisrv_pkg::cmd_t cmd,
	output logic [CH_W-1:0]  ch
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_HDR  = 4'd2;
	localparam logic [3:0] S_RDLO = 4'd3;
	localparam logic [3:0] S_RDHI = 4'd4;
	localparam logic [3:0] S_CONV = 4'd5;
	localparam logic [3:0] S_MUL  = 4'd6;
	localparam logic [3:0] S_CH   = 4'd7;
	localparam logic [3:0] S_CRC  = 4'd8;

	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNEL_COUNT - 1);

	logic [3:0]      state_q, state_d;
	logic [1:0]      bidx_q, bidx_d;
	logic [CH_W-1:0] ch_q, ch_d;

	assign req_stall = (state_q != S_IDLE);
	assign ch        = ch_q;

	always_comb begin
		state_d = state_q;
		bidx_d  = bidx_q;
		ch_d    = ch_q;
		cmd     = '0;
		cmd.out_sel = spisrv_pkg::SEL_READ;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (sts.is_read) begin
						cmd.acc_rd = 1'b1;
						state_d    = S_RD;
					end else begin
						cmd.acc_wr = 1'b1;
						if (sts.is_trig) begin
							cmd.crc_clr = 1'b1;
							bidx_d      = 2'd0;
							ch_d        = '0;
							state_d     = S_HDR;
						end
					end
				end
			end
			S_RD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = spisrv_pkg::SEL_READ;
					state_d      = S_IDLE;
				end
			end
			S_HDR: begin
				unique case (bidx_q)
					2'd0:    cmd.out_sel = spisrv_pkg::SEL_CMD;
					2'd1:    cmd.out_sel = spisrv_pkg::SEL_LEN;
					default: cmd.out_sel = spisrv_pkg::SEL_ZERO;
				endcase
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					bidx_d       = bidx_q + 2'd1;
					if (bidx_q == 2'd3) begin
						state_d = S_RDLO;
					end
				end
			end
			S_RDLO: begin
				cmd.ch_re = 1'b1;
				state_d   = S_RDHI;
			end
			S_RDHI: begin
				cmd.cap_lo = 1'b1;
				cmd.ch_re  = 1'b1;
				cmd.ch_hi  = 1'b1;
				state_d    = S_CONV;
			end
			S_CONV: begin
				cmd.cap_raw = 1'b1;
				state_d     = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				bidx_d     = 2'd0;
				state_d    = S_CH;
			end
			S_CH: begin
				unique case (bidx_q)
					2'd0:    cmd.out_sel = spisrv_pkg::SEL_ID;
					2'd1:    cmd.out_sel = spisrv_pkg::SEL_ZERO;
					2'd2:    cmd.out_sel = spisrv_pkg::SEL_VHI;
					default: cmd.out_sel = spisrv_pkg::SEL_VLO;
				endcase
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					bidx_d       = bidx_q + 2'd1;
					if (bidx_q == 2'd3) begin
						if (ch_q == CH_LAST) begin
							state_d = S_CRC;
						end else begin
							ch_d    = ch_q + CH_W'(1);
							state_d = S_RDLO;
						end
					end
				end
			end
			S_CRC: begin
				cmd.out_sel = spisrv_pkg::SEL_CRC;
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bidx_q  <= 2'd0;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			bidx_q  <= bidx_d;
			ch_q    <= ch_d;
		end
	end

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("reply register overwritten while still held");

	a_crc_clr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.crc_clr |-> (state_q == S_IDLE) && req_valid)
		else $error("CRC cleared outside a packet trigger");

	a_crc_last_ch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CRC) |-> (ch_q == CH_LAST))
		else $error("CRC byte reached before the last channel");
`endif

endmodule

// ===== hw/rtl/spi_register_file_to_servo_packet.sv =====
// Top level of the SPI register file with servo packet generator.
// Depends on spisrv_pkg, spisrv_ctrl and spisrv_dp.
//
// Each request is one bus access to a 128-byte register file that reads as
// zero after reset (per-entry valid flags, so no clearing pass is needed).
// A read returns one reply byte (result_type 0, last_byte 1). A write stores
// the byte and gives no reply, except a write to register 127 with bit 0 set:
// that stores the byte with bit 0 cleared and sends a servo packet of
// 5 + 4*CHANNEL_COUNT bytes (result_type 1): 0xA4, the length, two zeros, then
// per channel its id, a zero and the high and low bytes of the value held in
// registers 2c/2c+1 (little endian) mapped from 800..2200 onto 0..0xFFFF with
// clamping, then a Dallas/Maxim CRC-8 byte flagged with last_byte.
// A write is stored as it is taken. A read goes through the registered RAM
// read, then the reply register once that is free. A packet holds the request
// side until its CRC byte is loaded: each channel takes two reads on the
// single RAM read port, a range check and the conversion multiply, then four
// byte loads, each of which waits while the reply register is still held.
// The reply register lets the next request be taken while the last reply
// still waits to be taken.
module spi_register_file_to_servo_packet #(
	parameter int unsigned CHANNEL_COUNT = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  spisrv_pkg::req_t req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output spisrv_pkg::rsp_t rsp
);

	// channel counter width; one channel still needs one bit
	localparam int unsigned CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

	spisrv_pkg::cmd_t cmd;
	spisrv_pkg::sts_t sts;
	logic [CH_W-1:0]  ch;

	// sequence accesses and packet bytes
	spisrv_ctrl #(
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.CH_W         (CH_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd),
		.ch       (ch)
	);

	// storage, conversion, CRC and the reply register
	spisrv_dp #(
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.CH_W         (CH_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.ch       (ch),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule
